[hw/rtl/rcsf_pkg.sv]
// Shared types and constants of the RGB color sequence fader.
package rcsf_pkg;

    localparam int MAX_COLORS = 16;
    localparam int IDX_W      = $clog2(MAX_COLORS);
    localparam int CNT_W      = $clog2(MAX_COLORS + 1);
    localparam int POS_W      = 17;
    localparam int HOLD_W     = 16;
    localparam int FADE_W     = 16;
    localparam int COLOR_W    = 24;
    localparam int DIVIDEND_W = 24;
    localparam int DIVISOR_W  = 16;
    localparam int DIVCNT_W   = $clog2(DIVIDEND_W);

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_LOAD    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [1:0] CFG_FADE_TICKS = 2'd0;
    localparam logic [1:0] CFG_NUM_COLORS = 2'd1;
    localparam logic [1:0] CFG_STOP_AFTER = 2'd2;

    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [COLOR_W-1:0] color;
        logic [HOLD_W-1:0]  hold;
    } tbl_wr_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [HOLD_W-1:0]  hold;
    } tbl_rd_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

[hw/rtl/rgb_color_sequence_fader_top.sv]
// Top level of the RGB color sequence fader: sequencer, state and output word register.
// A load writes one table entry; a restart shows entry 0; a fading tick runs the
// serial divider (24 steps per channel) for blue, green then red; a hold tick skips it.
// Throughput: one input word at a time; the next is taken once the result is loaded.
// Ticks while stopped and unused codes are accepted and give no result.
// Reset (rst_n, async, active low) clears state and output valid, sets config defaults; tables start unwritten.
module rgb_color_sequence_fader_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [3:0]  entry_index,
    input  logic [7:0]  entry_red,
    input  logic [7:0]  entry_green,
    input  logic [7:0]  entry_blue,
    input  logic [15:0] entry_hold,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red_level,
    output logic [7:0]  green_level,
    output logic [7:0]  blue_level,
    output logic        red_on,
    output logic        green_on,
    output logic        blue_on,
    output logic [3:0]  segment_now,
    output logic        still_running,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import rcsf_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_RDS  = 8'b0000_0010,
        ST_RDN  = 8'b0000_0100,
        ST_POS  = 8'b0000_1000,
        ST_CHK  = 8'b0001_0000,
        ST_MUL  = 8'b0010_0000,
        ST_DIV  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg;

    logic [FADE_W-1:0]  fade_reg;
    logic [CNT_W-1:0]   num_reg;
    logic               stop_reg;

    logic [POS_W-1:0]   position_reg;
    logic [IDX_W-1:0]   segment_reg;
    logic [COLOR_W-1:0] current_color_reg;
    logic               running_reg;

    logic               restart_reg;
    logic [IDX_W-1:0]   seg_reg;
    logic [IDX_W-1:0]   next_reg;
    logic [COLOR_W-1:0] start_reg;
    logic [COLOR_W-1:0] end_reg;
    logic [HOLD_W-1:0]  hold_reg;
    logic [POS_W-1:0]   pos_new_reg;
    logic [POS_W-1:0]   end_sum_reg;
    logic [FADE_W-1:0]  t_reg;
    logic [1:0]         ch_reg;
    logic               neg_reg;

    logic               out_valid_reg;

    logic               in_accept;
    logic               out_free;
    logic [CNT_W-1:0]   n_eff;
    logic [IDX_W-1:0]   last_idx;
    logic [IDX_W-1:0]   seg_sel;
    logic [IDX_W-1:0]   next_sel;
    logic [FADE_W-1:0]  fade_eff;
    logic [POS_W-1:0]   t_diff;
    logic               over_hold;
    logic               seg_end;
    logic [7:0]         s_byte;
    logic [7:0]         e_byte;
    logic [7:0]         mag;
    logic [7:0]         q_byte;
    logic [7:0]         v_byte;

    tbl_wr_t            tbl_wr;
    tbl_rd_t            tbl_rd;
    logic [IDX_W-1:0]   tbl_addr;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    assign in_stall  = state_reg != ST_IDLE;
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (num_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (num_reg > CNT_W'(MAX_COLORS))
        begin
            n_eff = CNT_W'(MAX_COLORS);
        end
        else
        begin
            n_eff = num_reg;
        end
    end

    assign last_idx = IDX_W'(n_eff - 1'b1);
    assign seg_sel  = ({1'b0, segment_reg} < n_eff) ? segment_reg : last_idx;
    assign next_sel = (seg_sel >= last_idx) ? '0 : seg_sel + 1'b1;
    assign fade_eff = (fade_reg == '0) ? FADE_W'(1) : fade_reg;

    assign t_diff    = pos_new_reg - {1'b0, hold_reg};
    assign over_hold = pos_new_reg > {1'b0, hold_reg};
    assign seg_end   = pos_new_reg >= end_sum_reg;

    always_comb
    begin
        case (ch_reg)
            CH_BLUE:
            begin
                s_byte = start_reg[7:0];
                e_byte = end_reg[7:0];
            end
            CH_GREEN:
            begin
                s_byte = start_reg[15:8];
                e_byte = end_reg[15:8];
            end
            default:
            begin
                s_byte = start_reg[23:16];
                e_byte = end_reg[23:16];
            end
        endcase
    end

    assign mag    = (e_byte < s_byte) ? s_byte - e_byte : e_byte - s_byte;
    assign q_byte = div_rsp.quotient[7:0];
    assign v_byte = neg_reg ? s_byte - q_byte : s_byte + q_byte;

    assign tbl_wr.en    = in_accept && (action == ACT_LOAD);
    assign tbl_wr.addr  = entry_index;
    assign tbl_wr.color = {entry_red, entry_green, entry_blue};
    assign tbl_wr.hold  = entry_hold;
    assign tbl_addr     = (state_reg == ST_RDN) ? next_reg : seg_reg;

    assign div_req.start    = state_reg == ST_MUL;
    assign div_req.dividend = DIVIDEND_W'(t_reg) * DIVIDEND_W'(mag);
    assign div_req.divisor  = fade_eff;

    rcsf_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_addr (tbl_addr),
        .rd      (tbl_rd)
    );

    rcsf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_reg <= FADE_W'(1);
            num_reg  <= CNT_W'(1);
            stop_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FADE_TICKS: fade_reg <= cfg_data;
                CFG_NUM_COLORS: num_reg  <= cfg_data[CNT_W-1:0];
                CFG_STOP_AFTER: stop_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            position_reg      <= '0;
            segment_reg       <= '0;
            current_color_reg <= '0;
            running_reg       <= 1'b0;
            restart_reg       <= 1'b0;
            seg_reg           <= '0;
            next_reg          <= '0;
            ch_reg            <= CH_BLUE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && action == ACT_RESTART)
                    begin
                        restart_reg <= 1'b1;
                        seg_reg     <= '0;
                        state_reg   <= ST_RDS;
                    end
                    else if (in_accept && action == ACT_TICK && running_reg)
                    begin
                        restart_reg <= 1'b0;
                        seg_reg     <= seg_sel;
                        next_reg    <= next_sel;
                        state_reg   <= ST_RDS;
                    end
                end
                ST_RDS:
                begin
                    state_reg <= ST_RDN;
                end
                ST_RDN:
                begin
                    if (restart_reg)
                    begin
                        current_color_reg <= tbl_rd.color;
                        segment_reg       <= '0;
                        position_reg      <= '0;
                        running_reg       <= 1'b1;
                        state_reg         <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_POS;
                    end
                end
                ST_POS:
                begin
                    state_reg <= ST_CHK;
                end
                ST_CHK:
                begin
                    if (seg_end)
                    begin
                        position_reg <= '0;
                        segment_reg  <= next_reg;
                        if (stop_reg)
                        begin
                            running_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        position_reg <= pos_new_reg;
                        segment_reg  <= seg_reg;
                    end
                    if (over_hold)
                    begin
                        ch_reg    <= CH_BLUE;
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        current_color_reg <= start_reg;
                        state_reg         <= ST_OUT;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        case (ch_reg)
                            CH_BLUE:  current_color_reg[7:0]   <= v_byte;
                            CH_GREEN: current_color_reg[15:8]  <= v_byte;
                            default:  current_color_reg[23:16] <= v_byte;
                        endcase
                        if (ch_reg == CH_RED)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RDN)
        begin
            start_reg <= tbl_rd.color;
            hold_reg  <= tbl_rd.hold;
        end
        if (state_reg == ST_POS)
        begin
            end_reg     <= tbl_rd.color;
            pos_new_reg <= position_reg + 1'b1;
            end_sum_reg <= POS_W'(hold_reg) + POS_W'(fade_eff);
        end
        if (state_reg == ST_CHK)
        begin
            t_reg <= (t_diff > POS_W'(fade_eff)) ? fade_eff : t_diff[FADE_W-1:0];
        end
        if (state_reg == ST_MUL)
        begin
            neg_reg <= e_byte < s_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            red_level     <= current_color_reg[23:16];
            green_level   <= current_color_reg[15:8];
            blue_level    <= current_color_reg[7:0];
            red_on        <= current_color_reg[23:16] != 8'd0;
            green_on      <= current_color_reg[15:8] != 8'd0;
            blue_on       <= current_color_reg[7:0] != 8'd0;
            segment_now   <= segment_reg;
            still_running <= running_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_stop_only_when_enabled: assert property (
        @(posedge clk) disable iff (!rst_n)
        $fell(running_reg) |-> $past(stop_reg)
    ) else $error("running cleared without stop_after_segment");

    a_div_done_in_wait: assert property (
        @(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV
    ) else $error("divider finished outside its wait state");

    a_out_from_out_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT)
    ) else $error("result word loaded outside the output state");

endmodule

[hw/rtl/rcsf_table.sv]
// Color and hold table memory with one write port and one registered read port.
module rcsf_table (
    input  logic                     clk,
    input  rcsf_pkg::tbl_wr_t        wr,
    input  logic [rcsf_pkg::IDX_W-1:0] rd_addr,
    output rcsf_pkg::tbl_rd_t        rd
);
    import rcsf_pkg::*;

    tbl_rd_t mem [MAX_COLORS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= '{color: wr.color, hold: wr.hold};
        end
        rd <= mem[rd_addr];
    end

endmodule

[hw/rtl/rcsf_div.sv]
// Restoring serial divider, one quotient bit per cycle.
module rcsf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  rcsf_pkg::div_req_t req,
    output rcsf_pkg::div_rsp_t rsp
);
    import rcsf_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVCNT_W-1:0]   cnt_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == DIVCNT_W'(DIVIDEND_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
